// ----- hdl/fit_policy_block_allocator_top_assert.svh -----
// assertion macros shared by the allocator modules
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define FPBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FPBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fpba_pkg.sv -----
package fpba_pkg;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic writeback;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ----- hdl/fit_policy_block_allocator_top.sv -----
// First, best or worst fit allocator over a table of per-block free space.
// A load item writes a block's free size and gives no result.
// An allocate item reads the table one block per cycle through the single
// read port of the table memory, over min(blocks_in_use, NUM_BLOCKS) blocks,
// then writes the reduced size back; busy stays high through that scan and
// the write-back, and a new item is taken only while busy is low. The result
// is shown for exactly one cycle, marked by done, in the first cycle with
// busy low, and cannot be held off: the receiver must take it then. Every
// allocate item gives one result, even when nothing fits. The table is all
// zero after reset.
module fit_policy_block_allocator_top #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [3:0]  block_index,
  input  logic [15:0] block_size,
  input  logic [15:0] request_size,
  output logic        done,
  output logic        allocated,
  output logic [3:0]  chosen_block,
  output logic [15:0] space_left
);

  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  logic [1:0] fit_policy;
  logic [4:0] blocks_in_use;
  logic       cfg_wr;
  logic       reg_sel;

  fpba_pkg::cmd_t    cmd;
  fpba_pkg::status_t st;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= fpba_pkg::POL_FIRST;
      blocks_in_use <= 5'd16;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FIT_POLICY:    fit_policy    <= pwdata[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= pwdata[4:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIT_POLICY:    prdata = {30'd0, fit_policy};
      REG_BLOCKS_IN_USE: prdata = {27'd0, blocks_in_use};
      default:           prdata = 32'd0;
    endcase
  end

  fpba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .fit_policy    (fit_policy),
    .blocks_in_use (blocks_in_use),
    .block_index   (block_index),
    .block_size    (block_size),
    .request_size  (request_size),
    .done          (done),
    .allocated     (allocated),
    .chosen_block  (chosen_block),
    .space_left    (space_left)
  );

endmodule

// ----- hdl/fpba_ctrl.sv -----
module fpba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             action,
  input  fpba_pkg::status_t st,
  output fpba_pkg::cmd_t   cmd,
  output logic             busy
);

`include "fit_policy_block_allocator_top_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == fpba_pkg::ACT_ALLOC) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          state_next = ST_WB;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_WB: begin
        cmd.writeback = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `FPBA_ASSERT_NEXT(a_alloc_enters_scan, start && !busy && action == fpba_pkg::ACT_ALLOC,
                    state == ST_SCAN, "allocate item did not start a scan")
  `FPBA_ASSERT_NEXT(a_scan_ends_in_wb, state == ST_SCAN && st.scan_done,
                    state == ST_WB, "finished scan did not go to write-back")
  `FPBA_ASSERT_NEXT(a_wb_single, state == ST_WB, state == ST_IDLE,
                    "write-back lasted more than one cycle")

endmodule

// ----- hdl/fpba_dp.sv -----
module fpba_dp #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  fpba_pkg::cmd_t cmd,
  output fpba_pkg::status_t st,
  input  logic [1:0]     fit_policy,
  input  logic [4:0]     blocks_in_use,
  input  logic [3:0]     block_index,
  input  logic [15:0]    block_size,
  input  logic [15:0]    request_size,
  output logic           done,
  output logic           allocated,
  output logic [3:0]     chosen_block,
  output logic [15:0]    space_left
);

`include "fit_policy_block_allocator_top_assert.svh"

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [15:0]           mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld;
  logic [15:0]           mem_q;
  logic                  vld_q;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             cmp_en;
  logic [IDX_W-1:0] cmp_idx;

  logic             found;
  logic [IDX_W-1:0] pick;
  logic [15:0]      best;
  logic [15:0]      req;

  logic [31:0]      load_ext;
  logic [IDX_W-1:0] load_addr;
  logic             load_ok;
  logic [15:0]      cand;
  logic             better;
  logic             take;
  logic [15:0]      remain;
  logic [31:0]      pick_ext;

  always_comb begin
    if (32'(blocks_in_use) > NUM_BLOCKS) begin
      limit = CNT_W'(NUM_BLOCKS);
    end else begin
      limit = CNT_W'(blocks_in_use);
    end
  end

  assign st.scan_done = (scan_idx >= limit);
  assign rd_addr      = scan_idx[IDX_W-1:0];

  assign load_ext  = 32'(block_index);
  assign load_addr = load_ext[IDX_W-1:0];
  assign load_ok   = cmd.load && (load_ext < NUM_BLOCKS);

  assign remain   = best - req;
  assign pick_ext = 32'(pick);

  // entry never written reads as zero
  assign cand = vld_q ? mem_q : 16'd0;

  always_comb begin
    unique case (fit_policy)
      fpba_pkg::POL_BEST:  better = (cand < best);
      fpba_pkg::POL_WORST: better = (cand > best);
      default:             better = 1'b0;
    endcase
  end

  assign take = cmp_en && (cand >= req) && (!found || better);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[load_addr] <= block_size;
    end else if (cmd.writeback && found) begin
      mem[pick] <= remain;
    end
    if (cmd.scan_step) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (load_ok) begin
      vld[load_addr] <= 1'b1;
    end else if (cmd.writeback && found) begin
      vld[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en   <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= cmd.writeback;
      if (cmd.scan_init) begin
        scan_idx <= '0;
        cmp_en   <= 1'b0;
        found    <= 1'b0;
      end else begin
        cmp_en <= cmd.scan_step;
        if (cmd.scan_step) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      req <= request_size;
    end
    if (cmd.scan_step) begin
      cmp_idx <= rd_addr;
    end
    if (take) begin
      pick <= cmp_idx;
      best <= cand;
    end
    if (cmd.writeback) begin
      allocated <= found;
      if (found) begin
        chosen_block <= pick_ext[3:0];
        space_left   <= remain;
      end else begin
        chosen_block <= 4'd0;
        space_left   <= 16'd0;
      end
    end
  end

  `FPBA_ASSERT_NEXT(a_wb_gives_result, cmd.writeback, done,
                    "write-back did not produce a result")
  `FPBA_ASSERT_IMPL(a_miss_is_zero, done && !allocated,
                    chosen_block == 4'd0 && space_left == 16'd0,
                    "not-allocated result carries a block or space")
  `FPBA_ASSERT_NEXT(a_init_clears, cmd.scan_init, !found && !cmp_en && scan_idx == '0,
                    "scan start left stale search state")
  `FPBA_ASSERT_IMPL(a_cmp_follows_read, cmp_en, $past(cmd.scan_step),
                    "compare without a table read in the cycle before")

endmodule
